>>> hdl/sim_pkg.sv
// ----------------------------------------------------------------------------
// sim_pkg
// Shared types and constants of the safety interlock monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sim_pkg;

  // debounce counter and threshold width
  localparam int unsigned CntW = 10;
  localparam logic [CntW-1:0] CntMax = '1;

  // temperature sample and hysteresis widths
  localparam int unsigned TempW = 16;
  localparam int unsigned HystW = 15;
  // compare width that holds cutoff minus hysteresis without wrap
  localparam int unsigned CmpW  = TempW + 2;

  // tick timestamp width
  localparam int unsigned TimeW = 32;

  // fault flag bit positions
  localparam int unsigned FlagW       = 3;
  localparam int unsigned FlagStop    = 0;
  localparam int unsigned FlagCover   = 1;
  localparam int unsigned FlagThermal = 2;

  // configuration bus
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  // register map, word index
  typedef enum logic [1:0] {
    RegEstopTicks = 2'd0,
    RegCoverTicks = 2'd1,
    RegCutoff     = 2'd2,
    RegHysteresis = 2'd3
  } reg_idx_e;

  // reset values of the registers
  localparam logic [CntW-1:0]         EstopTicksRst = CntW'(50);
  localparam logic [CntW-1:0]         CoverTicksRst = CntW'(50);
  localparam logic signed [TempW-1:0] CutoffRst     = TempW'(4000);
  localparam logic [HystW-1:0]        HystRst       = HystW'(160);

  // per-fault status for the current word: state after it and new-fault strobe
  typedef struct packed {
    logic active;
    logic raised;
  } fault_stat_t;

endpackage

`default_nettype wire

>>> hdl/sim_if.sv
// ----------------------------------------------------------------------------
// sim_in_if / sim_out_if
// Valid/ready channels carrying tick words in and status words out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sim_in_if;
  logic                              valid;
  logic                              ready;
  logic                              stop_level;
  logic                              cover_level;
  logic signed [sim_pkg::TempW-1:0]  temperature;

  modport source (output valid, output stop_level, output cover_level,
                  output temperature, input ready);
  modport sink   (input valid, input stop_level, input cover_level,
                  input temperature, output ready);
endinterface

interface sim_out_if;
  logic                        valid;
  logic                        ready;
  logic [sim_pkg::FlagW-1:0]   fault_bits;
  logic                        all_ok;
  logic                        shutdown;
  logic [sim_pkg::TimeW-1:0]   fault_time;

  modport source (output valid, output fault_bits, output all_ok,
                  output shutdown, output fault_time, input ready);
  modport sink   (input valid, input fault_bits, input all_ok,
                  input shutdown, input fault_time, output ready);
endinterface

`default_nettype wire

>>> hdl/sim_debounce.sv
// ----------------------------------------------------------------------------
// sim_debounce
// Saturating debounce counter for one active-low switch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sim_debounce (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      step_i,
  input  wire logic                      level_i,
  input  wire logic [sim_pkg::CntW-1:0]  limit_i,
  output sim_pkg::fault_stat_t           stat_o
);

  logic [sim_pkg::CntW-1:0] count_q, count_d;
  logic                     active_q, active_d;
  logic [sim_pkg::CntW-1:0] count_sat;

  // next counter and fault state for the word in flight
  always_comb begin
    count_sat     = (count_q == sim_pkg::CntMax) ? count_q : count_q + 1'b1;
    stat_o.raised = 1'b0;
    if (!level_i) begin
      count_d       = count_sat;
      stat_o.raised = (count_sat >= limit_i) && !active_q;
      active_d      = active_q || (count_sat >= limit_i);
    end else begin
      count_d  = '0;
      active_d = 1'b0;
    end
    stat_o.active = active_d;
  end

  // state advances once per processed word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      active_q <= 1'b0;
    end else if (step_i) begin
      count_q  <= count_d;
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/sim_thermal.sv
// ----------------------------------------------------------------------------
// sim_thermal
// Thermal cutoff with hysteresis: set at or above cutoff, clear below
// cutoff minus hysteresis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sim_thermal (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              step_i,
  input  wire logic signed [sim_pkg::TempW-1:0]  temp_i,
  input  wire logic signed [sim_pkg::TempW-1:0]  cutoff_i,
  input  wire logic [sim_pkg::HystW-1:0]         hyst_i,
  output sim_pkg::fault_stat_t                   stat_o
);

  logic                              active_q, active_d;
  logic signed [sim_pkg::CmpW-1:0]   clear_below;
  logic                              hot, cold;

  // clear threshold in a wider signed range so it never wraps
  assign clear_below = sim_pkg::CmpW'(cutoff_i)
                     - $signed({{(sim_pkg::CmpW-sim_pkg::HystW){1'b0}}, hyst_i});
  assign hot  = temp_i >= cutoff_i;
  assign cold = sim_pkg::CmpW'(temp_i) < clear_below;

  always_comb begin
    priority if (hot) begin
      active_d = 1'b1;
    end else if (cold) begin
      active_d = 1'b0;
    end else begin
      active_d = active_q;
    end
    stat_o.active = active_d;
    stat_o.raised = hot && !active_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (step_i) begin
      active_q <= active_d;
    end
  end

endmodule

`default_nettype wire

>>> hdl/safety_interlock_monitor_core.sv
// ----------------------------------------------------------------------------
// safety_interlock_monitor_core
// Debounced e-stop and cover interlock with thermal hysteresis and a
// latched shutdown request, fed one word per monitoring tick.
// ----------------------------------------------------------------------------
// Every input word is one monitoring tick and yields exactly one status word.
// A word is captured in an input register and processed once the output
// register is free or being read, where the debounce counters, thermal state,
// tick counter and fault timestamp update and the result is loaded into the
// output register. One word can be accepted every cycle while the output
// side does not stall. The input side keeps accepting while a result waits
// in the output register; it stalls only when both stages are full.
// Registers are written over the APB port and should only change while no
// word is in flight. The shutdown request stays latched until reset.
`timescale 1ns / 1ps
`default_nettype none

module safety_interlock_monitor_core (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  sim_in_if.sink                              in_i,
  sim_out_if.source                           out_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sim_pkg::ApbAddrW-1:0]   paddr,
  input  wire logic [sim_pkg::ApbDataW-1:0]   pwdata,
  output logic      [sim_pkg::ApbDataW-1:0]   prdata,
  output logic                                pready
);

  // configuration registers
  logic [sim_pkg::CntW-1:0]          estop_ticks_q;
  logic [sim_pkg::CntW-1:0]          cover_ticks_q;
  logic signed [sim_pkg::TempW-1:0]  cutoff_q;
  logic [sim_pkg::HystW-1:0]         hyst_q;
  sim_pkg::reg_idx_e                 reg_idx;
  logic                              cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = sim_pkg::reg_idx_e'(paddr[sim_pkg::ApbAddrW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      estop_ticks_q <= sim_pkg::EstopTicksRst;
      cover_ticks_q <= sim_pkg::CoverTicksRst;
      cutoff_q      <= sim_pkg::CutoffRst;
      hyst_q        <= sim_pkg::HystRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        sim_pkg::RegEstopTicks: estop_ticks_q <= pwdata[sim_pkg::CntW-1:0];
        sim_pkg::RegCoverTicks: cover_ticks_q <= pwdata[sim_pkg::CntW-1:0];
        sim_pkg::RegCutoff:     cutoff_q      <= $signed(pwdata[sim_pkg::TempW-1:0]);
        sim_pkg::RegHysteresis: hyst_q        <= pwdata[sim_pkg::HystW-1:0];
        default:                ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_idx)
      sim_pkg::RegEstopTicks: prdata = sim_pkg::ApbDataW'(estop_ticks_q);
      sim_pkg::RegCoverTicks: prdata = sim_pkg::ApbDataW'(cover_ticks_q);
      sim_pkg::RegCutoff:     prdata = sim_pkg::ApbDataW'($unsigned(cutoff_q));
      sim_pkg::RegHysteresis: prdata = sim_pkg::ApbDataW'(hyst_q);
      default:                prdata = '0;
    endcase
  end

  // input register
  logic                              s1_valid_q;
  logic                              s1_stop_q;
  logic                              s1_cover_q;
  logic signed [sim_pkg::TempW-1:0]  s1_temp_q;
  logic                              adv;
  logic                              in_acc;

  assign adv        = s1_valid_q && (!out_o.valid || out_o.ready);
  assign in_i.ready = !s1_valid_q || adv;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_stop_q  <= in_i.stop_level;
      s1_cover_q <= in_i.cover_level;
      s1_temp_q  <= in_i.temperature;
    end
  end

  // fault detectors
  sim_pkg::fault_stat_t stop_stat, cover_stat, therm_stat;

  sim_debounce u_stop (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .level_i (s1_stop_q),
    .limit_i (estop_ticks_q),
    .stat_o  (stop_stat)
  );

  sim_debounce u_cover (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (adv),
    .level_i (s1_cover_q),
    .limit_i (cover_ticks_q),
    .stat_o  (cover_stat)
  );

  sim_thermal u_thermal (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (adv),
    .temp_i   (s1_temp_q),
    .cutoff_i (cutoff_q),
    .hyst_i   (hyst_q),
    .stat_o   (therm_stat)
  );

  // tick counter, timestamp and shutdown latch
  logic [sim_pkg::TimeW-1:0]  tick_q;
  logic [sim_pkg::TimeW-1:0]  fault_time_q, fault_time_d;
  logic                       shutdown_q, shutdown_d;
  logic                       raised;
  logic [sim_pkg::FlagW-1:0]  flags_d;

  assign raised       = stop_stat.raised || cover_stat.raised || therm_stat.raised;
  assign fault_time_d = raised ? tick_q : fault_time_q;
  assign shutdown_d   = shutdown_q || raised;

  always_comb begin
    flags_d                       = '0;
    flags_d[sim_pkg::FlagStop]    = stop_stat.active;
    flags_d[sim_pkg::FlagCover]   = cover_stat.active;
    flags_d[sim_pkg::FlagThermal] = therm_stat.active;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      fault_time_q <= '0;
      shutdown_q   <= 1'b0;
    end else if (adv) begin
      tick_q       <= tick_q + 1'b1;
      fault_time_q <= fault_time_d;
      shutdown_q   <= shutdown_d;
    end
  end

  // output register
  logic                       out_valid_q;
  logic [sim_pkg::FlagW-1:0]  out_flags_q;
  logic                       out_ok_q;
  logic                       out_shut_q;
  logic [sim_pkg::TimeW-1:0]  out_time_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_flags_q <= flags_d;
      out_ok_q    <= (flags_d == '0);
      out_shut_q  <= shutdown_d;
      out_time_q  <= fault_time_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.fault_bits  = out_flags_q;
  assign out_o.all_ok      = out_ok_q;
  assign out_o.shutdown    = out_shut_q;
  assign out_o.fault_time  = out_time_q;

  // shutdown latch never drops outside reset
  a_shutdown_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shutdown_q |=> shutdown_q)
    else $error("shutdown latch cleared");

  // tick counter advances by one per processed word
  a_tick_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> tick_q == $past(tick_q) + 1'b1)
    else $error("tick counter step wrong");

  // any reported fault implies the shutdown request
  a_fault_shutdown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_flags_q != '0) |-> out_shut_q)
    else $error("fault reported without shutdown");

  // all-ok agrees with the flags
  a_all_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_ok_q == (out_flags_q == '0)))
    else $error("all_ok inconsistent with fault flags");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the safety interlock monitor core.
// ----------------------------------------------------------------------------
// Tick words go in over a valid/ready channel with random gaps. Status words
// come out under random back-pressure, including one long hold that fills
// the core and stalls its input. A scoreboard class keeps its own copy of the
// debounce counters, thermal state, tick counter and shutdown latch. It
// predicts one status word per accepted tick and compares every field with
// the word that comes out. The registers are rewritten over APB between
// phases while nothing is in flight. The settings include the debounce and
// temperature extremes, a zero debounce count and a clear threshold that
// lies below the temperature range.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;

  // cycles without any accepted word before the run is abandoned
  localparam int unsigned StallLimit = 3000;
  // length of the forced receiver hold
  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [sim_pkg::FlagW-1:0] fault_bits;
    logic                      all_ok;
    logic                      shutdown;
    logic [sim_pkg::TimeW-1:0] fault_time;
  } status_t;

  // interlock predictor and store of expected status words
  class interlock_scoreboard;
    logic [sim_pkg::CntW-1:0]         stop_limit;
    logic [sim_pkg::CntW-1:0]         cover_limit;
    logic signed [sim_pkg::TempW-1:0] cutoff;
    logic [sim_pkg::HystW-1:0]        hyst;
    logic [sim_pkg::CntW-1:0]         stop_cnt;
    logic [sim_pkg::CntW-1:0]         cover_cnt;
    bit                               stop_on;
    bit                               cover_on;
    bit                               hot_on;
    bit                               shut_latched;
    logic [sim_pkg::TimeW-1:0]        tick_now;
    logic [sim_pkg::TimeW-1:0]        last_raise;
    status_t                          pending[$];
    int unsigned                      errors;

    function new();
      stop_limit   = sim_pkg::EstopTicksRst;
      cover_limit  = sim_pkg::CoverTicksRst;
      cutoff       = sim_pkg::CutoffRst;
      hyst         = sim_pkg::HystRst;
      stop_cnt     = '0;
      cover_cnt    = '0;
      stop_on      = 1'b0;
      cover_on     = 1'b0;
      hot_on       = 1'b0;
      shut_latched = 1'b0;
      tick_now     = '0;
      last_raise   = '0;
      errors       = 0;
    endfunction

    function void set_reg(sim_pkg::reg_idx_e idx, logic [sim_pkg::ApbDataW-1:0] value);
      case (idx)
        sim_pkg::RegEstopTicks: stop_limit  = value[sim_pkg::CntW-1:0];
        sim_pkg::RegCoverTicks: cover_limit = value[sim_pkg::CntW-1:0];
        sim_pkg::RegCutoff:     cutoff      = value[sim_pkg::TempW-1:0];
        sim_pkg::RegHysteresis: hyst        = value[sim_pkg::HystW-1:0];
        default: ;
      endcase
    endfunction

    // saturating low counter, returns 1 when the fault newly raises
    function bit debounce(input logic level, input logic [sim_pkg::CntW-1:0] limit,
                          inout logic [sim_pkg::CntW-1:0] cnt, inout bit on);
      if (level == 1'b0) begin
        if (cnt < sim_pkg::CntMax) cnt = cnt + 1'b1;
        if (cnt >= limit && !on) begin
          on = 1'b1;
          return 1'b1;
        end
      end else begin
        cnt = '0;
        on  = 1'b0;
      end
      return 1'b0;
    endfunction

    function void note_tick(logic stop_lvl, logic cover_lvl,
                            logic signed [sim_pkg::TempW-1:0] temp);
      bit      raised;
      int      clear_below;
      status_t exp;
      raised = debounce(stop_lvl, stop_limit, stop_cnt, stop_on);
      if (debounce(cover_lvl, cover_limit, cover_cnt, cover_on)) raised = 1'b1;
      // thermal hysteresis, clear threshold computed without wrap
      clear_below = int'(cutoff) - int'(hyst);
      if (int'(temp) >= int'(cutoff)) begin
        if (!hot_on) begin
          hot_on = 1'b1;
          raised = 1'b1;
        end
      end else if (int'(temp) < clear_below) begin
        hot_on = 1'b0;
      end
      if (raised) begin
        last_raise   = tick_now;
        shut_latched = 1'b1;
      end
      tick_now = tick_now + 1'b1;
      exp.fault_bits = '0;
      exp.fault_bits[sim_pkg::FlagStop]    = stop_on;
      exp.fault_bits[sim_pkg::FlagCover]   = cover_on;
      exp.fault_bits[sim_pkg::FlagThermal] = hot_on;
      exp.all_ok      = (exp.fault_bits == '0);
      exp.shutdown    = shut_latched;
      exp.fault_time  = last_raise;
      pending.push_back(exp);
    endfunction

    function void check_status(status_t got);
      status_t exp;
      if (pending.size() == 0) begin
        $display("%0t: status word with none expected: flags %0d ok %0d shut %0d time %0d",
                 $time, got.fault_bits, got.all_ok, got.shutdown, got.fault_time);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.fault_bits !== exp.fault_bits) begin
        $display("%0t: fault_bits expected %0d, got %0d",
                 $time, exp.fault_bits, got.fault_bits);
        errors++;
      end
      if (got.all_ok !== exp.all_ok) begin
        $display("%0t: all_ok expected %0d, got %0d", $time, exp.all_ok, got.all_ok);
        errors++;
      end
      if (got.shutdown !== exp.shutdown) begin
        $display("%0t: shutdown expected %0d, got %0d", $time, exp.shutdown, got.shutdown);
        errors++;
      end
      if (got.fault_time !== exp.fault_time) begin
        $display("%0t: fault_time expected %0d, got %0d",
                 $time, exp.fault_time, got.fault_time);
        errors++;
      end
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [sim_pkg::ApbAddrW-1:0] paddr;
  logic [sim_pkg::ApbDataW-1:0] pwdata;
  logic [sim_pkg::ApbDataW-1:0] prdata;
  logic                         pready;

  sim_in_if  in_bus();
  sim_out_if out_bus();

  interlock_scoreboard sb = new();

  bit          no_gaps;
  int unsigned hold_requests;

  safety_interlock_monitor_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // switch run length: low runs reach up to three past the debounce count, capped at 43
  function automatic int unsigned run_len(logic level, logic [sim_pkg::CntW-1:0] limit);
    int unsigned top;
    if (level) return $urandom_range(1, 6);
    top = (limit > 40) ? 43 : int'(limit) + 3;
    return $urandom_range(1, top);
  endfunction

  // temperature near the set or clear threshold, sometimes anywhere
  function automatic logic signed [sim_pkg::TempW-1:0] pick_temp();
    int          v;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 35) v = int'(sb.cutoff) + int'($urandom_range(0, 8)) - 4;
    else if (r < 65) v = int'(sb.cutoff) - int'(sb.hyst) + int'($urandom_range(0, 8)) - 4;
    else if (r < 85) v = int'(sb.cutoff) - int'($urandom_range(0, sb.hyst));
    else return $signed(sim_pkg::TempW'($urandom));
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return sim_pkg::TempW'(v);
  endfunction

  // offer one tick word and wait for its handshake
  task automatic send_tick(input logic stop_lvl, input logic cover_lvl,
                           input logic signed [sim_pkg::TempW-1:0] temp);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_bus.valid       <= 1'b1;
    in_bus.stop_level  <= stop_lvl;
    in_bus.cover_level <= cover_lvl;
    in_bus.temperature <= temp;
    do @(posedge clk_i); while (!in_bus.ready);
    sb.note_tick(stop_lvl, cover_lvl, temp);
  endtask

  // apb register write: setup cycle then access cycle
  task automatic write_reg(input sim_pkg::reg_idx_e idx,
                           input logic [sim_pkg::ApbDataW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  // let every word drain, then rewrite all registers
  task automatic configure(input logic [sim_pkg::CntW-1:0] stop_ticks,
                           input logic [sim_pkg::CntW-1:0] cover_ticks,
                           input logic signed [sim_pkg::TempW-1:0] cut,
                           input logic [sim_pkg::HystW-1:0] margin);
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    write_reg(sim_pkg::RegEstopTicks, sim_pkg::ApbDataW'(stop_ticks));
    write_reg(sim_pkg::RegCoverTicks, sim_pkg::ApbDataW'(cover_ticks));
    write_reg(sim_pkg::RegCutoff, sim_pkg::ApbDataW'(cut));
    write_reg(sim_pkg::RegHysteresis, sim_pkg::ApbDataW'(margin));
  endtask

  // random ticks: switch runs around the debounce count plus some noise
  task automatic run_phase(input int unsigned n_items, input int unsigned hold_at);
    logic                    stop_run;
    logic                    cover_run;
    int unsigned             stop_left;
    int unsigned             cover_left;
    logic                    s;
    logic                    c;
    stop_run   = 1'b1;
    cover_run  = 1'b1;
    stop_left  = 0;
    cover_left = 0;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (stop_left == 0) begin
        stop_run  = ~stop_run;
        stop_left = run_len(stop_run, sb.stop_limit);
      end
      if (cover_left == 0) begin
        cover_run  = ~cover_run;
        cover_left = run_len(cover_run, sb.cover_limit);
      end
      stop_left--;
      cover_left--;
      s = stop_run;
      c = cover_run;
      if ($urandom_range(0, 9) == 0) begin
        s = 1'($urandom);
        c = 1'($urandom);
      end
      if (k == hold_at) hold_requests++;
      send_tick(s, c, pick_temp());
    end
  endtask

  // result side: random stalls and the forced long hold
  initial begin : result_sink
    int unsigned stall_left;
    int unsigned holds_done;
    stall_left = 0;
    holds_done = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        stall_left = HoldCycles;
      end else if (stall_left == 0 && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_bus.ready <= 1'b0;
        stall_left--;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // compare each accepted status word
  always @(posedge clk_i) begin : status_check
    status_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.fault_bits  = out_bus.fault_bits;
      got.all_ok      = out_bus.all_ok;
      got.shutdown    = out_bus.shutdown;
      got.fault_time  = out_bus.fault_time;
      sb.check_status(got);
    end
  end

  // watchdog on cycles with no word moving on either side
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("[safety_interlock_monitor_core] ERROR");
    $finish;
  end

  // stimulus
  initial begin : stimulus
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    in_bus.valid       <= 1'b0;
    in_bus.stop_level  <= 1'b1;
    in_bus.cover_level <= 1'b1;
    in_bus.temperature <= '0;
    no_gaps            = 1'b0;
    hold_requests      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: thermal set and clear edges, short low runs
    send_tick(1'b1, 1'b1, 16'sd0);
    send_tick(1'b1, 1'b1, 16'sd32767);
    send_tick(1'b1, 1'b1, 16'sd3840);
    send_tick(1'b1, 1'b1, 16'sd3839);
    send_tick(1'b1, 1'b1, 16'sd3999);
    send_tick(1'b1, 1'b1, 16'sd4000);
    send_tick(1'b1, 1'b1, -16'sd32768);
    send_tick(1'b0, 1'b0, 16'sd0);
    send_tick(1'b0, 1'b1, 16'sd0);
    send_tick(1'b1, 1'b1, 16'sd0);

    // short debounce counts, fault already active keeps its timestamp
    configure(10'd1, 10'd2, 16'sd4000, 15'd160);
    send_tick(1'b0, 1'b1, 16'sd0);
    send_tick(1'b0, 1'b0, 16'sd0);
    send_tick(1'b0, 1'b0, 16'sd0);
    send_tick(1'b0, 1'b0, 16'sd0);
    send_tick(1'b1, 1'b1, 16'sd0);

    // zero debounce count, all three faults on one tick, no hysteresis
    configure(10'd0, 10'd1, 16'sd100, 15'd0);
    send_tick(1'b0, 1'b0, 16'sd100);
    send_tick(1'b1, 1'b1, 16'sd99);

    // clear threshold below the temperature range: thermal never clears
    configure(10'd1, 10'd1, -16'sd32768, 15'd32767);
    send_tick(1'b1, 1'b1, -16'sd32768);
    send_tick(1'b1, 1'b1, 16'sd32767);
    send_tick(1'b1, 1'b1, -16'sd32768);

    // long debounce counts, held low past the raise
    configure(10'd100, 10'd99, 16'sd4000, 15'd160);
    repeat (104) send_tick(1'b0, 1'b0, 16'sd0);
    send_tick(1'b1, 1'b1, 16'sd0);

    // random phases over several settings
    configure(10'd1, 10'd1023, 16'sd0, 15'd0);
    no_gaps = 1'b1;
    run_phase(132, 200);
    no_gaps = 1'b0;
    configure(10'd5, 10'd3, -16'sd200, 15'd40);
    run_phase(132, 60);
    configure(sim_pkg::CntW'($urandom_range(1, 20)), sim_pkg::CntW'($urandom_range(1, 20)),
              $signed(sim_pkg::TempW'($urandom)), sim_pkg::HystW'($urandom));
    run_phase(132, 200);
    configure(10'd1023, 10'd1, 16'sd32767, 15'd32767);
    run_phase(132, 200);
    configure(10'd0, 10'd0, -16'sd32768, 15'd0);
    run_phase(132, 200);
    configure(10'd12, 10'd30, 16'sd4000, 15'd160);
    run_phase(132, 90);
    configure(sim_pkg::CntW'($urandom_range(1, 30)), sim_pkg::CntW'($urandom_range(1, 30)),
              $signed(sim_pkg::TempW'($urandom)), sim_pkg::HystW'($urandom_range(0, 300)));
    run_phase(132, 200);

    // drain and finish
    in_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[safety_interlock_monitor_core] OK");
    else
      $display("[safety_interlock_monitor_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire
